@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the word engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, checked only outside reset.
`define PBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define PBB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pbb_pkg.sv @@
// Types, codes and helper functions of the planar bit-block word engine.
package pbb_pkg;

  localparam int MAX_PLANES = 8;

  localparam logic [2:0] REG_SKEW          = 3'd0;
  localparam logic [2:0] REG_LEFT_EDGE     = 3'd1;
  localparam logic [2:0] REG_RIGHT_EDGE    = 3'd2;
  localparam logic [2:0] REG_OP_TABLE      = 3'd3;
  localparam logic [2:0] REG_FG_COLOR      = 3'd4;
  localparam logic [2:0] REG_BG_COLOR      = 3'd5;
  localparam logic [2:0] REG_RIGHT_TO_LEFT = 3'd6;

  localparam logic CMD_SRC = 1'b0;
  localparam logic CMD_DST = 1'b1;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_MIDDLE = 2'd1;
  localparam logic [1:0] POS_LAST   = 2'd2;
  localparam logic [1:0] POS_ONLY   = 2'd3;

  localparam logic [3:0]  SKEW_RESET       = 4'd0;
  localparam logic [3:0]  LEFT_EDGE_RESET  = 4'd0;
  localparam logic [3:0]  RIGHT_EDGE_RESET = 4'd15;
  localparam logic [15:0] OP_TABLE_RESET   = 16'h3333;

  typedef struct packed {
    logic [3:0]  skew;
    logic [3:0]  left_edge;
    logic [3:0]  right_edge;
    logic [15:0] op_table;
    logic [7:0]  fg_color;
    logic [7:0]  bg_color;
    logic        right_to_left;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] data_word;
    logic        line_start;
    logic [1:0]  word_pos;
    logic [2:0]  plane;
  } item_t;

  // Raster op on 16 bits: op bit 3 covers ~s&~d, bit 2 ~s&d, bit 1 s&~d, bit 0 s&d.
  function automatic logic [15:0] apply_rop(input logic [3:0] op, input logic [15:0] s,
                                            input logic [15:0] d);
    apply_rop = ({16{op[3]}} & ~s & ~d) | ({16{op[2]}} & ~s & d) |
                ({16{op[1]}} & s & ~d)  | ({16{op[0]}} & s & d);
  endfunction

  function automatic logic [15:0] edge_mask(input cfg_t cfg, input logic [1:0] pos);
    logic [15:0] lmask;
    logic [15:0] rmask;
    lmask = 16'hFFFF >> cfg.left_edge;
    rmask = ~(16'hFFFF >> ({1'b0, cfg.right_edge} + 5'd1));
    case (pos)
      POS_FIRST:  edge_mask = cfg.right_to_left ? rmask : lmask;
      POS_LAST:   edge_mask = cfg.right_to_left ? lmask : rmask;
      POS_ONLY:   edge_mask = lmask & rmask;
      default:    edge_mask = 16'hFFFF;
    endcase
  endfunction

endpackage

@@ src/pbb_cfg.sv @@
// Configuration register file of the word engine.
module pbb_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output pbb_pkg::cfg_t cfg
);
  import pbb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skew          <= SKEW_RESET;
      cfg.left_edge     <= LEFT_EDGE_RESET;
      cfg.right_edge    <= RIGHT_EDGE_RESET;
      cfg.op_table      <= OP_TABLE_RESET;
      cfg.fg_color      <= 8'd0;
      cfg.bg_color      <= 8'd0;
      cfg.right_to_left <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKEW:          cfg.skew          <= cfg_data[3:0];
        REG_LEFT_EDGE:     cfg.left_edge     <= cfg_data[3:0];
        REG_RIGHT_EDGE:    cfg.right_edge    <= cfg_data[3:0];
        REG_OP_TABLE:      cfg.op_table      <= cfg_data;
        REG_FG_COLOR:      cfg.fg_color      <= cfg_data[7:0];
        REG_BG_COLOR:      cfg.bg_color      <= cfg_data[7:0];
        REG_RIGHT_TO_LEFT: cfg.right_to_left <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/pbb_datapath.sv @@
// Funnel register and masked raster-op logic of the word engine.
module pbb_datapath #(
  parameter int MAX_PLANES = pbb_pkg::MAX_PLANES
) (
  input  logic           clk,
  input  logic           rst,
  input  pbb_pkg::cfg_t  cfg,
  input  pbb_pkg::item_t item,
  input  logic           advance,
  output logic [15:0]    result_word
);
  import pbb_pkg::*;

  logic [31:0] funnel;
  logic [31:0] funnel_next;
  logic [31:0] funnel_base;
  logic        fg_bit;
  logic        bg_bit;
  logic [3:0]  op;
  logic [15:0] src_win;
  logic [15:0] mask;

  // A line start empties the funnel before the new word goes in.
  always_comb begin
    funnel_base = item.line_start ? 32'd0 : funnel;
    if (cfg.right_to_left) begin
      funnel_next = {item.data_word, funnel_base[31:16]};
    end else begin
      funnel_next = {funnel_base[15:0], item.data_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      funnel <= 32'd0;
    end else if (advance && item.cmd == CMD_SRC) begin
      funnel <= funnel_next;
    end
  end

  // Planes past the last one read both color bits as zero.
  always_comb begin
    fg_bit = 1'b0;
    bg_bit = 1'b0;
    if (int'(item.plane) < MAX_PLANES) begin
      fg_bit = cfg.fg_color[item.plane];
      bg_bit = cfg.bg_color[item.plane];
    end
    case ({fg_bit, bg_bit})
      2'd0:    op = cfg.op_table[3:0];
      2'd1:    op = cfg.op_table[7:4];
      2'd2:    op = cfg.op_table[11:8];
      default: op = cfg.op_table[15:12];
    endcase
    src_win     = 16'(funnel >> cfg.skew);
    mask        = edge_mask(cfg, item.word_pos);
    result_word = (item.data_word & ~mask) | (apply_rop(op, src_win, item.data_word) & mask);
  end

endmodule

@@ src/planar_bitblt_word_engine.sv @@
// Top level of the planar bit-block transfer word engine.
//
// Words arrive on the input channel (in_valid/in_ready) with cmd, data_word,
// line_start, word_pos and plane. A source word (cmd 0) is shifted into the
// 32-bit funnel and gives no result. A destination word (cmd 1) is combined
// with the funnel window by the raster op chosen for its plane, edge masked,
// and leaves as result_word on the output channel (out_valid/out_ready).
// An accepted destination word is registered in the input stage, and its
// result is then loaded into the output register that drives out_valid and
// result_word. Throughput is one word per cycle while the receiver takes
// results, set by the single input register feeding the result register.
// When the receiver stalls, the result waits in the output register; source
// words keep flowing, and one destination word may wait in the input stage
// before in_ready drops. Reset clears the funnel, both stage valid flags and
// loads the register defaults (skew 0, left edge 0, right edge 15, op table
// 0x3333, colors 0, left to right). The user must write registers through
// cfg_we, cfg_index and cfg_data only while no word is in flight; the block
// itself does not enforce this.
module planar_bitblt_word_engine #(
  parameter int MAX_PLANES = pbb_pkg::MAX_PLANES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] data_word,
  input  logic        line_start,
  input  logic [1:0]  word_pos,
  input  logic [2:0]  plane,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_word
);
  import pbb_pkg::*;

  `include "assert_macros.svh"

  cfg_t        cfg;
  item_t       stage;
  logic        stage_valid;
  logic        advance;
  logic        dst_done;
  logic [15:0] comb_result;

  pbb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbb_datapath #(
    .MAX_PLANES (MAX_PLANES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (stage),
    .advance     (advance),
    .result_word (comb_result)
  );

  // A source word never needs the output register, so it always moves on.
  // A destination word moves on when the output register is free or being
  // emptied in this cycle.
  assign advance  = stage_valid && (stage.cmd == CMD_SRC || !out_valid || out_ready);
  assign dst_done = advance && stage.cmd == CMD_DST;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.cmd        <= cmd;
      stage.data_word  <= data_word;
      stage.line_start <= line_start;
      stage.word_pos   <= word_pos;
      stage.plane      <= plane;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dst_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dst_done) begin
      result_word <= comb_result;
    end
  end

  `PBB_ASSERT(a_src_never_stalls, (stage_valid && stage.cmd == CMD_SRC) |-> in_ready, "src stalled")
  `PBB_ASSERT(a_dst_gives_result, dst_done |=> out_valid, "destination word produced no result")
  `PBB_ASSERT(a_taken_clears, (out_valid && out_ready && !dst_done) |=> !out_valid, "result repeated")
  `PBB_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !stage_valid), "word survived reset")

endmodule

@@ tb/planar_bitblt_word_engine_tb.sv @@
// Self-checking testbench for the planar bit-block word engine against a predictor.
`timescale 1ns / 1ps

module planar_bitblt_word_engine_tb;
  import pbb_pkg::*;

  // Register index that decodes to nothing; writes to it must be ignored.
  localparam logic [2:0] REG_NONE = 3'd7;

  // Receiver stall patterns.
  localparam int RX_FREE   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_TOGGLE = 3;

  localparam int TOTAL_WORDS       = 1730;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES      = 8;
  localparam int LIMIT_CYCLES      = 200000;
  localparam int REPORT_LIMIT      = 10;

  // A destination word together with the result it should produce.
  typedef struct packed {
    item_t       word;
    logic [15:0] result;
  } dest_check_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [15:0] data_word = 16'd0;
  logic        line_start = 1'b0;
  logic [1:0]  word_pos = 2'd0;
  logic [2:0]  plane = 3'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] result_word;

  planar_bitblt_word_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .data_word   (data_word),
    .line_start  (line_start),
    .word_pos    (word_pos),
    .plane       (plane),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_word (result_word)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and results still owed by the DUT.
  item_t       pending_words[$];
  dest_check_t owed_results[$];

  // Our own copy of the register file and the funnel. The register copy is
  // only changed while nothing is in flight, so it always matches what the
  // DUT uses for the words being checked.
  cfg_t        cfg_model = '{skew: SKEW_RESET, left_edge: LEFT_EDGE_RESET,
                             right_edge: RIGHT_EDGE_RESET, op_table: OP_TABLE_RESET,
                             fg_color: 8'd0, bg_color: 8'd0, right_to_left: 1'b0};
  logic [31:0] funnel_model = 32'd0;

  int words_queued = 0;
  int src_words = 0;
  int dst_words = 0;
  int results_checked = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int phases = 0;
  int cycle_count = 0;
  int stalls_requested = 0;
  int stalls_served = 0;

  // Builds the new destination word: raster op of the shifted funnel window
  // against the old word, limited to the bits of the edge mask. Each result
  // bit picks op bit 3 - {s, d}, which is the same truth table as the
  // sum-of-products form of the op.
  function automatic logic [15:0] blend_dest(input item_t w);
    logic [1:0]  sel;
    logic [3:0]  rop;
    logic [31:0] shifted;
    logic [15:0] win;
    logic [15:0] rop_out;
    logic [15:0] lmask;
    logic [15:0] rmask;
    logic [15:0] keep;
    int          i;
    sel = 2'b00;
    if (w.plane < MAX_PLANES) begin
      sel = {cfg_model.fg_color[w.plane], cfg_model.bg_color[w.plane]};
    end
    rop = cfg_model.op_table[4*sel +: 4];
    shifted = funnel_model >> cfg_model.skew;
    win = shifted[15:0];
    for (i = 0; i < 16; i++) begin
      rop_out[i] = rop[2'd3 - {win[i], w.data_word[i]}];
      // Positions are counted from the MSB: the left mask keeps pixels at or
      // right of the start, the right mask keeps pixels at or left of the end.
      lmask[15-i] = (i >= cfg_model.left_edge);
      rmask[15-i] = (i <= cfg_model.right_edge);
    end
    case (w.word_pos)
      POS_FIRST: keep = cfg_model.right_to_left ? rmask : lmask;
      POS_LAST:  keep = cfg_model.right_to_left ? lmask : rmask;
      POS_ONLY:  keep = lmask & rmask;
      default:   keep = 16'hFFFF;
    endcase
    return (w.data_word & ~keep) | (rop_out & keep);
  endfunction

  // Source words move the funnel by half its width; the new word lands in
  // the low half going left to right and in the high half going right to left.
  function automatic logic [31:0] loaded_funnel(input logic [31:0] f, input item_t w);
    logic [31:0] base;
    base = w.line_start ? 32'd0 : f;
    if (cfg_model.right_to_left) begin
      return {w.data_word, base[31:16]};
    end
    return {base[15:0], w.data_word};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Offers words from the pending queue at the falling edge, in bursts
  // of random length separated by random gaps. A word that has been offered
  // stays on the port, unchanged, until the rising edge that accepts it.
  // ---------------------------------------------------------------------------
  logic  word_taken = 1'b0;
  item_t drive_word;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // Still waiting for the current word to be taken.
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_words.size() != 0) begin
      drive_word = pending_words.pop_front();
      in_valid   <= 1'b1;
      cmd        <= drive_word.cmd;
      data_word  <= drive_word.data_word;
      line_start <= drive_word.line_start;
      word_pos   <= drive_word.word_pos;
      plane      <= drive_word.plane;
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        // Some bursts are long and followed by no gap at all, so there are
        // stretches where the sender never idles.
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Switches between stall patterns at random. When the stimulus
  // asks for it, it holds off for a long stretch so that the DUT fills up
  // and drops in_ready while the driver keeps offering words.
  // ---------------------------------------------------------------------------
  int rx_mode = RX_FREE;
  int rx_mode_left = 0;
  int rx_tick = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stalls_served < stalls_requested) begin
      stalls_served++;
      hold_left = LONG_STALL_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(RX_FREE, RX_TOGGLE);
        rx_mode_left = $urandom_range(16, 96);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
        default:   out_ready <= rx_tick[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge it first checks a result leaving the DUT
  // against the oldest owed result, then records a word entering the DUT:
  // source words update the funnel copy, destination words add an owed result.
  // Doing both in one process keeps the queue free of ordering races.
  // ---------------------------------------------------------------------------
  item_t       seen_word;
  dest_check_t oldest;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results still owed", cycle_count,
               owed_results.size());
      $display("Mismatches found");
      $finish;
    end
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Unexpected result word %h with nothing owed", result_word);
          end
        end else begin
          oldest = owed_results.pop_front();
          results_checked++;
          if (result_word !== oldest.result) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("Result mismatch for dest %h pos %0d plane %0d: expected %h, got %h",
                       oldest.word.data_word, oldest.word.word_pos, oldest.word.plane,
                       oldest.result, result_word);
            end
          end
        end
      end
      word_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        seen_word = '{cmd: cmd, data_word: data_word, line_start: line_start,
                      word_pos: word_pos, plane: plane};
        if (seen_word.cmd == CMD_SRC) begin
          funnel_model = loaded_funnel(funnel_model, seen_word);
          src_words++;
        end else begin
          owed_results.push_back('{word: seen_word, result: blend_dest(seen_word)});
          dst_words++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_word(input logic c, input logic [15:0] d, input logic ls,
                            input logic [1:0] pos, input logic [2:0] pl);
    pending_words.push_back('{cmd: c, data_word: d, line_start: ls, word_pos: pos, plane: pl});
    words_queued++;
  endtask

  // Register writes go out on consecutive cycles; the copy is updated at the
  // same time, which is safe because no word is in flight.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SKEW:          cfg_model.skew = val[3:0];
      REG_LEFT_EDGE:     cfg_model.left_edge = val[3:0];
      REG_RIGHT_EDGE:    cfg_model.right_edge = val[3:0];
      REG_OP_TABLE:      cfg_model.op_table = val;
      REG_FG_COLOR:      cfg_model.fg_color = val[7:0];
      REG_BG_COLOR:      cfg_model.bg_color = val[7:0];
      REG_RIGHT_TO_LEFT: cfg_model.right_to_left = val[0];
      default:           ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [15:0] skew_v, left_v, right_v, ops_v, fg_v, bg_v,
                           dir_v);
    write_reg(REG_SKEW, skew_v);
    write_reg(REG_LEFT_EDGE, left_v);
    write_reg(REG_RIGHT_EDGE, right_v);
    write_reg(REG_OP_TABLE, ops_v);
    write_reg(REG_FG_COLOR, fg_v);
    write_reg(REG_BG_COLOR, bg_v);
    write_reg(REG_RIGHT_TO_LEFT, dir_v);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random register data with random upper bits; the used low bits are
  // often forced to all zeros or all ones to reach the extremes.
  function automatic logic [15:0] reg_value(input logic [15:0] used_bits);
    logic [15:0] v;
    v = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       v = v & ~used_bits;
      1:       v = v | used_bits;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] word_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One blit line: a line-start source load, an optional second load, then
  // destination words tagged first, middle, last or only, most of them
  // preceded by a further source load as a fetch unit would issue them.
  task automatic queue_line();
    int         n;
    int         k;
    logic [1:0] pos;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    queue_word(CMD_SRC, word_value(), 1'b1, 2'($urandom_range(0, 3)),
               3'($urandom_range(0, 7)));
    if ($urandom_range(0, 1) == 1) begin
      queue_word(CMD_SRC, word_value(), 1'b0, 2'($urandom_range(0, 3)),
                 3'($urandom_range(0, 7)));
    end
    for (k = 0; k < n; k++) begin
      if (n == 1) begin
        pos = POS_ONLY;
      end else if (k == 0) begin
        pos = POS_FIRST;
      end else if (k == n - 1) begin
        pos = POS_LAST;
      end else begin
        pos = POS_MIDDLE;
      end
      if (k > 0 && $urandom_range(0, 7) != 0) begin
        queue_word(CMD_SRC, word_value(), 1'b0, 2'($urandom_range(0, 3)),
                   3'($urandom_range(0, 7)));
      end
      // A line-start flag on a destination word should change nothing.
      queue_word(CMD_DST, word_value(), $urandom_range(0, 7) == 0, pos,
                 3'($urandom_range(0, 7)));
    end
  endtask

  // A few words with every field random, outside any line structure.
  task automatic queue_noise();
    int n;
    int k;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      queue_word(1'($urandom_range(0, 1)), word_value(), 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    end
  endtask

  // Waits until every word has gone in and every owed result has come out,
  // then lets a source word still in the pipe settle before registers change.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    phases++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int         k;
    int         p;
    int         target;
    logic [3:0] op_base;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: straight source copy, full masks, left to right.
    queue_word(CMD_SRC, 16'hFFFF, 1'b1, POS_ONLY, 3'd0);
    queue_word(CMD_DST, 16'h0000, 1'b0, POS_ONLY, 3'd7);
    drain();

    // Directed part. Four op tables together hold all sixteen raster ops, and
    // colors 0xCC/0xAA make planes 0..3 (and again 4..7) select each of the
    // four table entries. Shifts, edges and direction go to their extremes.
    for (k = 0; k < 4; k++) begin
      op_base = 4'(4 * k);
      case (k)
        0: configure(16'd0, 16'd0, 16'd15, {op_base + 4'd3, op_base + 4'd2, op_base + 4'd1,
                     op_base}, 16'h00CC, 16'h00AA, 16'd0);
        1: configure(16'hFFFF, 16'd15, 16'd0, {op_base + 4'd3, op_base + 4'd2,
                     op_base + 4'd1, op_base}, 16'hFFCC, 16'hFFAA, 16'hFFFF);
        2: configure(16'd7, 16'd8, 16'd7, {op_base + 4'd3, op_base + 4'd2, op_base + 4'd1,
                     op_base}, 16'h00CC, 16'h00AA, 16'hFFFE);
        default: configure(16'd1, 16'd1, 16'd14, {op_base + 4'd3, op_base + 4'd2,
                           op_base + 4'd1, op_base}, 16'h00CC, 16'h00AA, 16'd1);
      endcase
      queue_word(CMD_SRC, k[0] ? 16'h0000 : 16'hFFFF, 1'b1, POS_FIRST, 3'd0);
      queue_word(CMD_SRC, 16'h8001, 1'b0, POS_LAST, 3'd7);
      for (p = 0; p < 4; p++) begin
        queue_word(CMD_DST, (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF :
                   (p == 2) ? 16'h5A5A : 16'hA5A5, p == 1, 2'(p), 3'(k[0] ? 4 + p : p));
      end
      drain();
    end

    // Random part: a fresh register setting per phase, mostly well-formed
    // lines with some noise mixed in. Two phases start with a long receiver
    // hold-off to back the DUT up into its input.
    while (words_queued < TOTAL_WORDS) begin
      configure(reg_value(16'h000F), reg_value(16'h000F), reg_value(16'h000F),
                reg_value(16'hFFFF), reg_value(16'h00FF), reg_value(16'h00FF),
                reg_value(16'h0001));
      if (phases == 6 || phases == 14) begin
        stalls_requested++;
      end
      target = words_queued + $urandom_range(40, 110);
      while (words_queued < target) begin
        if ($urandom_range(0, 5) == 0) begin
          queue_noise();
        end else begin
          queue_line();
        end
      end
      drain();
    end

    $display("Run covered %0d source and %0d destination words in %0d phases, %0d register writes.",
             src_words, dst_words, phases, reg_writes);
    $display("Checked %0d results, %0d long receiver hold-offs, %0d cycles.",
             results_checked, stalls_served, cycle_count);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/pbb_pkg.sv
src/pbb_cfg.sv
src/pbb_datapath.sv
src/planar_bitblt_word_engine.sv
tb/planar_bitblt_word_engine_tb.sv
